// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the calendar conversion checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be seen at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// File: rtl/mjdc_pkg.sv
// ----------------------------------------------------------------------------
// mjdc_pkg
// Types, constants and the month offset table for the MJD to calendar block.
// ----------------------------------------------------------------------------
package mjdc_pkg;

  // Internal date path is sized for the widest supported day number.
  localparam int MJD_W = 23;
  localparam int B_W   = 24;
  localparam int N1_W  = 28;
  localparam int C_W   = 15;
  localparam int CM_W  = 26;
  localparam int X_W   = 9;
  localparam int N2_W  = 23;
  localparam int E_W   = 4;

  // Julian day offset: MJD to JD plus the Gregorian correction term.
  localparam int B_OFFSET   = 2400001 + 1537;
  // Year estimate works on 20*b - 20*122.1 over 20*365.25.
  localparam int YEAR_SCALE = 20;
  localparam int YEAR_BIAS  = 2442;
  localparam int N1_OFFSET  = YEAR_SCALE * B_OFFSET - YEAR_BIAS;

  // Reciprocal divide by 7305, exact for numerators below 2^28.
  localparam int C_DIV     = 7305;
  localparam int C_SHIFT   = 41;
  localparam int C_RECIP_W = 29;
  localparam logic [63:0] C_RECIP_FULL =
    ((64'd1 << C_SHIFT) + 64'(C_DIV) - 64'd1) / 64'(C_DIV);
  localparam logic [C_RECIP_W-1:0] C_RECIP = C_RECIP_FULL[C_RECIP_W-1:0];
  localparam int P1_W = N1_W + C_RECIP_W;

  // Four-year cycle length in days.
  localparam int D_MUL = 1461;

  // Reciprocal divide by 306001, exact for numerators below 2^23.
  localparam int E_SCALE   = 10000;
  localparam int E_DIV     = 306001;
  localparam int E_SHIFT   = 42;
  localparam int E_RECIP_W = 24;
  localparam logic [63:0] E_RECIP_FULL =
    ((64'd1 << E_SHIFT) + 64'(E_DIV) - 64'd1) / 64'(E_DIV);
  localparam logic [E_RECIP_W-1:0] E_RECIP = E_RECIP_FULL[E_RECIP_W-1:0];
  localparam int P2_W = N2_W + E_RECIP_W;

  localparam int YEAR_BASE  = 4715;
  localparam int MONTH_WRAP = 14;
  localparam int MARCH      = 3;

  localparam int HOURS_PER_DAY   = 24;
  localparam int MINS_PER_HOUR   = 60;
  localparam int SECS_PER_MINUTE = 60;

  localparam int YEAR_W  = 13;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int SUB_W   = 32;

  // Register stages in the date and time paths, and the port-to-port latency.
  localparam int PIPE_STAGES = 5;
  localparam int LATENCY     = PIPE_STAGES + 1;

  typedef struct packed {
    logic               neg;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } mjdc_date_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [SUB_W-1:0]  sub;
  } mjdc_tod_t;

  // floor(30.6001 * e): days before the month selected by e.
  function automatic logic [X_W-1:0] month_offset(input logic [E_W-1:0] e);
    logic [X_W-1:0] r;
    case (e)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      4'd15:   r = 9'd459;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/mjd_to_calendar.sv
// ----------------------------------------------------------------------------
// mjd_to_calendar
// Modified Julian Date and day fraction to Gregorian date and time of day.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// input     in         start / busy         in_mjd_day, in_day_fraction
// result    out        out_strobe (1 cycle) out_status, out_cal_*, out_*_of_*,
//                                           out_whole_second, out_sub_second
//
// One item is taken per cycle while busy is low. Each result passes through the
// five-stage date path (two reciprocal multiplies) and then the output register
// before it is on the result ports.
// busy is high only while reset is held and until a clock edge sees reset released.
// The result cannot be held off, so the pipeline never stalls.
// A negative day number returns status 1 with all other fields zero.
// ----------------------------------------------------------------------------
module mjd_to_calendar import mjdc_pkg::*; #(
  parameter int DAY_BITS      = 21,
  parameter int FRACTION_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [DAY_BITS-1:0] in_mjd_day,
  input  logic [FRACTION_BITS-1:0]   in_day_fraction,
  output logic                       out_strobe,
  output logic                       out_status,
  output logic [YEAR_W-1:0]          out_cal_year,
  output logic [MONTH_W-1:0]         out_cal_month,
  output logic [DAY_W-1:0]           out_cal_day,
  output logic [HOUR_W-1:0]          out_hour_of_day,
  output logic [MIN_W-1:0]           out_minute_of_hour,
  output logic [SEC_W-1:0]           out_whole_second,
  output logic [SUB_W-1:0]           out_sub_second
);

  logic                   busy_r;
  logic                   accept;
  logic [PIPE_STAGES-1:0] vld_r;
  logic [PIPE_STAGES-1:0] vld_nxt;
  mjdc_date_t             date;
  mjdc_tod_t              tod;

  assign accept  = start && !busy_r;
  assign vld_nxt = {vld_r[PIPE_STAGES-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= vld_nxt;
    end
  end

  mjdc_date #(
    .DAY_BITS (DAY_BITS)
  ) u_date (
    .clk     (clk),
    .mjd_day (in_mjd_day),
    .date    (date)
  );

  mjdc_time #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_time (
    .clk          (clk),
    .day_fraction (in_day_fraction),
    .tod          (tod)
  );

  // Output register; a rejected item clears every field but status.
  logic                out_strobe_r;
  logic                status_r;
  logic [YEAR_W-1:0]   year_r;
  logic [MONTH_W-1:0]  month_r;
  logic [DAY_W-1:0]    day_r;
  logic [HOUR_W-1:0]   hour_r;
  logic [MIN_W-1:0]    minute_r;
  logic [SEC_W-1:0]    second_r;
  logic [SUB_W-1:0]    sub_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vld_r[PIPE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    status_r <= date.neg;
    if (date.neg) begin
      year_r   <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      sub_r    <= '0;
    end else begin
      year_r   <= date.year;
      month_r  <= date.month;
      day_r    <= date.day;
      hour_r   <= tod.hour;
      minute_r <= tod.minute;
      second_r <= tod.second;
      sub_r    <= tod.sub;
    end
  end

  assign busy               = busy_r;
  assign out_strobe         = out_strobe_r;
  assign out_status         = status_r;
  assign out_cal_year       = year_r;
  assign out_cal_month      = month_r;
  assign out_cal_day        = day_r;
  assign out_hour_of_day    = hour_r;
  assign out_minute_of_hour = minute_r;
  assign out_whole_second   = second_r;
  assign out_sub_second     = sub_r;

endmodule

// File: rtl/mjdc_date.sv
// ----------------------------------------------------------------------------
// mjdc_date
// Five-stage date pipeline: day number to Gregorian year, month and day.
// ----------------------------------------------------------------------------
module mjdc_date import mjdc_pkg::*; #(
  parameter int DAY_BITS = 21
) (
  input  logic                       clk,
  input  logic signed [DAY_BITS-1:0] mjd_day,
  output mjdc_date_t                 date
);

  // Stage 1: Julian day base and scaled year numerator.
  logic [MJD_W-1:0] mag;
  logic [B_W-1:0]   b_nxt;
  logic [N1_W-1:0]  n1_nxt;
  logic             neg1_r;
  logic [B_W-1:0]   b1_r;
  logic [N1_W-1:0]  n1_r;

  assign mag    = MJD_W'(mjd_day[DAY_BITS-2:0]);
  assign b_nxt  = B_W'(mag) + B_W'(B_OFFSET);
  assign n1_nxt = N1_W'(mag) * N1_W'(YEAR_SCALE) + N1_W'(N1_OFFSET);

  always_ff @(posedge clk) begin
    neg1_r <= mjd_day[DAY_BITS-1];
    b1_r   <= b_nxt;
    n1_r   <= n1_nxt;
  end

  // Stage 2: reciprocal product for the year count.
  logic [P1_W-1:0] prod1_nxt;
  logic [P1_W-1:0] prod1_r;
  logic            neg2_r;
  logic [B_W-1:0]  b2_r;

  assign prod1_nxt = P1_W'(n1_r) * P1_W'(C_RECIP);

  always_ff @(posedge clk) begin
    neg2_r  <= neg1_r;
    b2_r    <= b1_r;
    prod1_r <= prod1_nxt;
  end

  // Stage 3: year count c and 1461*c.
  logic [C_W-1:0]  c_nxt;
  logic [CM_W-1:0] cm_nxt;
  logic [C_W-1:0]  c3_r;
  logic [CM_W-1:0] cm3_r;
  logic            neg3_r;
  logic [B_W-1:0]  b3_r;

  assign c_nxt  = prod1_r[C_SHIFT +: C_W];
  assign cm_nxt = CM_W'(c_nxt) * CM_W'(D_MUL);

  always_ff @(posedge clk) begin
    neg3_r <= neg2_r;
    b3_r   <= b2_r;
    c3_r   <= c_nxt;
    cm3_r  <= cm_nxt;
  end

  // Stage 4: day within the shifted year, scaled for the month divide.
  logic [B_W-1:0]  diff;
  logic [X_W-1:0]  x_nxt;
  logic [N2_W-1:0] n2_nxt;
  logic [X_W-1:0]  x4_r;
  logic [N2_W-1:0] n2_r;
  logic [C_W-1:0]  c4_r;
  logic            neg4_r;

  // The day within the year always lands in 123 to 488, so nine bits hold it.
  assign diff   = b3_r - cm3_r[CM_W-1:2];
  assign x_nxt  = diff[X_W-1:0];
  assign n2_nxt = N2_W'(x_nxt) * N2_W'(E_SCALE);

  always_ff @(posedge clk) begin
    neg4_r <= neg3_r;
    c4_r   <= c3_r;
    x4_r   <= x_nxt;
    n2_r   <= n2_nxt;
  end

  // Stage 5: reciprocal product for the month index.
  logic [P2_W-1:0] prod2_nxt;
  logic [P2_W-1:0] prod2_r;
  logic [X_W-1:0]  x5_r;
  logic [C_W-1:0]  c5_r;
  logic            neg5_r;

  assign prod2_nxt = P2_W'(n2_r) * P2_W'(E_RECIP);

  always_ff @(posedge clk) begin
    neg5_r  <= neg4_r;
    c5_r    <= c4_r;
    x5_r    <= x4_r;
    prod2_r <= prod2_nxt;
  end

  // Final selection: month, day of month and year from the month index.
  logic [E_W-1:0]     e;
  logic [X_W-1:0]     dom;
  logic [MONTH_W-1:0] month;
  logic [C_W-1:0]     year_full;

  assign e     = prod2_r[E_SHIFT +: E_W];
  assign dom   = x5_r - month_offset(e);
  assign month = (e >= E_W'(MONTH_WRAP)) ? MONTH_W'(e - E_W'(MONTH_WRAP - 1))
                                         : MONTH_W'(e - E_W'(1));
  assign year_full = c5_r - C_W'(YEAR_BASE)
                   - ((month >= MONTH_W'(MARCH)) ? C_W'(1) : C_W'(0));

  assign date.neg   = neg5_r;
  assign date.year  = year_full[YEAR_W-1:0];
  assign date.month = month;
  assign date.day   = dom[DAY_W-1:0];

endmodule

// File: rtl/mjdc_time.sv
// ----------------------------------------------------------------------------
// mjdc_time
// Time-of-day pipeline: three scaling stages, then delay to match the date path.
// ----------------------------------------------------------------------------
module mjdc_time import mjdc_pkg::*; #(
  parameter int FRACTION_BITS = 32
) (
  input  logic                     clk,
  input  logic [FRACTION_BITS-1:0] day_fraction,
  output mjdc_tod_t                tod
);

  localparam int FB        = FRACTION_BITS;
  localparam int H_W       = FB + 5;
  localparam int M_W       = FB + 6;
  localparam int TOD_DELAY = PIPE_STAGES - 3;

  // Stage 1: fraction times 24; the integer part is the hour.
  logic [H_W-1:0] p1_nxt;
  logic [H_W-1:0] p1_r;

  assign p1_nxt = H_W'(day_fraction) * H_W'(HOURS_PER_DAY);

  always_ff @(posedge clk) begin
    p1_r <= p1_nxt;
  end

  // Stage 2: remainder times 60 gives the minute.
  logic [M_W-1:0]    p2_nxt;
  logic [M_W-1:0]    p2_r;
  logic [HOUR_W-1:0] hr2_r;

  assign p2_nxt = M_W'(p1_r[FB-1:0]) * M_W'(MINS_PER_HOUR);

  always_ff @(posedge clk) begin
    p2_r  <= p2_nxt;
    hr2_r <= HOUR_W'(p1_r[H_W-1:FB]);
  end

  // Stage 3: remainder times 60 again gives the second and its fraction.
  logic [M_W-1:0]    p3_nxt;
  logic [M_W-1:0]    p3_r;
  logic [HOUR_W-1:0] hr3_r;
  logic [MIN_W-1:0]  mn3_r;
  mjdc_tod_t         tod3;

  assign p3_nxt = M_W'(p2_r[FB-1:0]) * M_W'(SECS_PER_MINUTE);

  always_ff @(posedge clk) begin
    p3_r  <= p3_nxt;
    hr3_r <= hr2_r;
    mn3_r <= MIN_W'(p2_r[M_W-1:FB]);
  end

  assign tod3.hour   = hr3_r;
  assign tod3.minute = mn3_r;
  assign tod3.second = SEC_W'(p3_r[M_W-1:FB]);
  assign tod3.sub    = SUB_W'(p3_r[FB-1:0]);

  // Delay line so the time of day lines up with the date result.
  mjdc_tod_t dly_r [TOD_DELAY];

  always_ff @(posedge clk) begin
    dly_r[0] <= tod3;
    for (int i = 1; i < TOD_DELAY; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  assign tod = dly_r[TOD_DELAY-1];

endmodule

// File: rtl/mjdc_checker.sv
// ----------------------------------------------------------------------------
// mjdc_checker
// Port-level checks on latency, status and result ranges of the converter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mjdc_checker import mjdc_pkg::*; #(
  parameter int DAY_BITS = 21
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic signed [DAY_BITS-1:0] in_mjd_day,
  input logic                       out_strobe,
  input logic                       out_status,
  input logic [YEAR_W-1:0]          out_cal_year,
  input logic [MONTH_W-1:0]         out_cal_month,
  input logic [DAY_W-1:0]           out_cal_day,
  input logic [HOUR_W-1:0]          out_hour_of_day,
  input logic [MIN_W-1:0]           out_minute_of_hour,
  input logic [SEC_W-1:0]           out_whole_second,
  input logic [SUB_W-1:0]           out_sub_second
);

  // Every accepted item gives exactly one result after the fixed latency.
  `ASSERT_IMPL(a_item_gives_result, clk, rst_n, start && !busy, ##LATENCY out_strobe, "accepted item produced no result")
  `ASSERT_IMPL(a_result_has_item, clk, rst_n, out_strobe, $past(start && !busy, LATENCY), "result without an accepted item")

  // Status follows the sign of the day number of the matching item.
  `ASSERT_IMPL(a_status_sign, clk, rst_n, out_strobe, out_status == $past(in_mjd_day[DAY_BITS-1], LATENCY), "status does not match the day sign")

  // A rejected item carries nothing but its status.
  `ASSERT_NEVER(a_reject_zero, clk, rst_n, out_strobe && out_status && (out_cal_year != '0 || out_cal_month != '0 || out_cal_day != '0 || out_hour_of_day != '0 || out_minute_of_hour != '0 || out_whole_second != '0 || out_sub_second != '0), "rejected item has nonzero fields")

  // A good result is a real date and time.
  `ASSERT_NEVER(a_ok_ranges, clk, rst_n, out_strobe && !out_status && (out_cal_month == '0 || out_cal_month > 4'd12 || out_cal_day == '0 || out_hour_of_day > 5'd23 || out_minute_of_hour > 6'd59 || out_whole_second > 6'd59), "result field out of range")

endmodule

bind mjd_to_calendar mjdc_checker #(
  .DAY_BITS (DAY_BITS)
) u_mjdc_checker (.*);

// File: test/mjd_to_calendar_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjd_to_calendar_tb
// Drives Modified Julian Dates with day fractions into the converter in random
// bursts, predicts each Gregorian date and time of day in the bench, and
// compares every strobed result field by field in order.
// ----------------------------------------------------------------------------
module mjd_to_calendar_tb;
  import mjdc_pkg::*;

  localparam int DAY_BITS      = 21;
  localparam int FRACTION_BITS = 32;
  localparam int RANDOM_ITEMS  = 1250;
  localparam int IDLE_LIMIT    = 2000;

  typedef struct packed {
    logic               status;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [SUB_W-1:0]   sub;
  } calendar_t;

  // Exact integer form of the Julian-day to calendar conversion.
  function automatic calendar_t calendar_from_mjd(logic signed [DAY_BITS-1:0] mjd,
                                                  logic [FRACTION_BITS-1:0] frac_in);
    calendar_t r;
    longint jb, jc, jd, je, dom, mon, yr;
    longint unsigned frac, prod;
    r = '0;
    if (mjd < 0) begin
      r.status = 1'b1;
      return r;
    end
    jb  = longint'(mjd) + 2400001 + 1537;
    jc  = (20 * jb - 2442) / 7305;
    jd  = (1461 * jc) / 4;
    je  = (10000 * (jb - jd)) / 306001;
    dom = jb - jd - (306001 * je) / 10000;
    mon = (je >= MONTH_WRAP) ? je - 13 : je - 1;
    yr  = jc - YEAR_BASE - ((mon >= MARCH) ? 1 : 0);
    r.year  = yr[YEAR_W-1:0];
    r.month = mon[MONTH_W-1:0];
    r.day   = dom[DAY_W-1:0];
    // Each time unit is the integer part of the scaled fraction; the rest carries on.
    frac     = longint'(frac_in);
    prod     = frac * HOURS_PER_DAY;
    r.hour   = prod[FRACTION_BITS+HOUR_W-1:FRACTION_BITS];
    frac     = prod[FRACTION_BITS-1:0];
    prod     = frac * MINS_PER_HOUR;
    r.minute = prod[FRACTION_BITS+MIN_W-1:FRACTION_BITS];
    frac     = prod[FRACTION_BITS-1:0];
    prod     = frac * SECS_PER_MINUTE;
    r.second = prod[FRACTION_BITS+SEC_W-1:FRACTION_BITS];
    r.sub    = prod[FRACTION_BITS-1:0];
    return r;
  endfunction

  class calendar_scoreboard;
    calendar_t pending_dates[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    function void note_item(logic signed [DAY_BITS-1:0] mjd, logic [FRACTION_BITS-1:0] frac);
      pending_dates.push_back(calendar_from_mjd(mjd, frac));
    endfunction

    function void compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(calendar_t act);
      calendar_t exp_r;
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, act);
        errors++;
        return;
      end
      exp_r = pending_dates.pop_front();
      compare_field("status", exp_r.status, act.status);
      compare_field("year", exp_r.year, act.year);
      compare_field("month", exp_r.month, act.month);
      compare_field("day", exp_r.day, act.day);
      compare_field("hour", exp_r.hour, act.hour);
      compare_field("minute", exp_r.minute, act.minute);
      compare_field("second", exp_r.second, act.second);
      compare_field("sub_second", exp_r.sub, act.sub);
    endfunction

    function int pending();
      return pending_dates.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic signed [DAY_BITS-1:0] in_mjd_day;
  logic [FRACTION_BITS-1:0]   in_day_fraction;
  logic                       out_strobe;
  logic                       out_status;
  logic [YEAR_W-1:0]          out_cal_year;
  logic [MONTH_W-1:0]         out_cal_month;
  logic [DAY_W-1:0]           out_cal_day;
  logic [HOUR_W-1:0]          out_hour_of_day;
  logic [MIN_W-1:0]           out_minute_of_hour;
  logic [SEC_W-1:0]           out_whole_second;
  logic [SUB_W-1:0]           out_sub_second;

  calendar_scoreboard sb;
  int                 idle_cycles;

  mjd_to_calendar #(
    .DAY_BITS      (DAY_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mjd_day         (in_mjd_day),
    .in_day_fraction    (in_day_fraction),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_cal_year       (out_cal_year),
    .out_cal_month      (out_cal_month),
    .out_cal_day        (out_cal_day),
    .out_hour_of_day    (out_hour_of_day),
    .out_minute_of_hour (out_minute_of_hour),
    .out_whole_second   (out_whole_second),
    .out_sub_second     (out_sub_second)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Items are taken and results checked on the values seen just before the edge.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      sb.note_item(in_mjd_day, in_day_fraction);
    end
    if (rst_n && out_strobe) begin
      sb.check_result({out_status, out_cal_year, out_cal_month, out_cal_day,
                       out_hour_of_day, out_minute_of_hour, out_whole_second,
                       out_sub_second});
    end
  end

  always @(posedge clk) begin
    if ((rst_n && start && !busy) || out_strobe || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(logic signed [DAY_BITS-1:0] mjd, logic [FRACTION_BITS-1:0] frac);
    @(negedge clk);
    start           <= 1'b1;
    in_mjd_day      <= mjd;
    in_day_fraction <= frac;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_input(int cycles);
    @(negedge clk);
    start           <= 1'b0;
    in_mjd_day      <= DAY_BITS'($urandom);
    in_day_fraction <= $urandom;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic logic signed [DAY_BITS-1:0] random_mjd();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return DAY_BITS'($urandom_range(0, 100000));
    if (pick < 70) return DAY_BITS'($urandom_range(0, (1 << (DAY_BITS - 1)) - 1));
    if (pick < 85) return DAY_BITS'($urandom);
    if (pick < 92) return DAY_BITS'($urandom_range(0, 64));
    return DAY_BITS'($urandom_range((1 << (DAY_BITS - 1)) - 64, (1 << (DAY_BITS - 1)) - 1));
  endfunction

  function automatic logic [FRACTION_BITS-1:0] random_fraction();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return $urandom;
    if (pick < 82) return '0;
    if (pick < 89) return '1;
    // Land near whole seconds, where the carries between units are most delicate.
    return FRACTION_BITS'(($urandom_range(0, 86399) * 64'd4294967296) / 86400
                          + $urandom_range(0, 2) - 1);
  endfunction

  initial begin
    int sent;
    int burst;
    sb              = new();
    idle_cycles     = 0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_mjd_day      = '0;
    in_day_fraction = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Extremes of both fields, negative days, and month and leap-year turnovers.
    send_item(0, 0);
    send_item(0, '1);
    send_item(21'sd1048575, 0);
    send_item(21'sd1048575, '1);
    send_item(-21'sd1, 32'hDEADBEEF);
    send_item(-21'sd1048576, '1);
    send_item(-21'sd524288, 0);
    send_item(21'sd51544, 32'h8000_0000);
    send_item(21'sd51603, 32'h4000_0000);
    send_item(21'sd51604, 32'hC000_0000);
    send_item(21'sd15078, 32'h0000_0001);
    send_item(21'sd15079, 32'hFFFF_FFFE);
    send_item(21'sd59944, 32'hAAAA_AAAB);
    send_item(21'sd59945, 32'h5555_5555);
    send_item(21'sd59975, 32'h0AAA_AAAB);
    send_item(21'sd59976, 32'h1234_5678);
    send_item(21'sd59974, 32'h8765_4321);
    send_item(21'sd60003, 32'h0000_B60B);
    send_item(21'sd60004, 32'hFFFF_4000);
    send_item(21'sd58849, 32'h7FFF_FFFF);
    send_item(21'sd58850, 32'h0004_C1F6);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_item(random_mjd(), random_fraction());
        sent++;
      end
      // Some bursts run straight into the next one.
      if ($urandom_range(0, 3) != 0) begin
        pause_input($urandom_range(1, 12));
      end
    end
    pause_input(1);

    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
